// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classification function of the
// base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// Width of the saturating byte counter.
	localparam int COUNT_WIDTH  = 16;
	// Width of the byte count carried by each result item.
	localparam int BYTE_COUNT_W = 16;
	// Counter width widened so that the reported count can be cut from it.
	localparam int CNT_EXT_W    = (COUNT_WIDTH > BYTE_COUNT_W) ? COUNT_WIDTH : BYTE_COUNT_W;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QLVL_W  = $clog2(QDEPTH + 1);

	// Stream widths.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// Special character codes.
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_PAD = 8'd61;

	// Position of a character within its group of four.
	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2,
		POS_FOURTH = 2'd3
	} pos_t;

	// One classified character, as queued between front and back.
	typedef struct packed {
		logic [5:0] sextet;
		logic       is_pad;
		logic       is_break;
		logic       last;
	} class_t;

	// Maps a character code to its sextet; anything outside the alphabet gives 0.
	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= 8'd65 && c <= 8'd90) begin
				v = c - 8'd65;
			end else if (c >= 8'd97 && c <= 8'd122) begin
				v = c - 8'd71;
			end else if (c >= 8'd48 && c <= 8'd57) begin
				v = c + 8'd4;
			end else if (c == 8'd43) begin
				v = 8'd62;
			end else if (c == 8'd47) begin
				v = 8'd63;
			end
			return v[5:0];
		end
	endfunction

endpackage

// ===== sv/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input characters, classifies them and hands them to the queue
// through one register stage.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] char_in
	input  logic                  s_tlast,   // end_of_text
	output logic                  push_valid,
	input  logic                  push_ready,
	output class_t                push_item
);

	logic   v_s1;
	class_t item_s1;
	logic   take;

	// The stage takes a new item whenever it is empty or is being drained.
	assign s_tready   = !v_s1 || push_ready;
	assign take       = s_tvalid && s_tready;
	assign push_valid = v_s1;
	assign push_item  = item_s1;

	// Valid flag of the classification stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// Classification of the accepted character.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.sextet   <= sextet_of(s_tdata);
			item_s1.is_pad   <= (s_tdata == CH_PAD);
			item_s1.is_break <= (s_tdata == CH_CR) || (s_tdata == CH_LF);
			item_s1.last     <= s_tlast;
		end
	end

endmodule

// ===== sv/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of classified characters between the front
// and the back.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  class_t            push_item,
	output logic              pop_valid,
	input  logic              pop,
	output class_t            pop_item,
	output logic [QLVL_W-1:0] level
);

	class_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QLVL_W-1:0]   level_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (level_q != QLVL_W'(QDEPTH));
	assign pop_valid  = (level_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = mem_q[rd_ptr_q];
	assign level      = level_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== sv/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Decodes classified characters in groups of four, keeps the byte count and
// drives the result stream from an output register.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  class_t                 q_item,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] byte_out, [23:8] byte_count
	output logic                   m_tuser,   // byte_valid
	output logic                   m_tlast    // end_of_data
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	pos_t                    pos_q;
	logic [5:0]              prev_q;
	logic [COUNT_WIDTH-1:0]  cnt_q;

	logic                    skip;
	logic                    have;
	logic [7:0]              byte_d;
	pos_t                    pos_d;
	logic [COUNT_WIDTH-1:0]  cnt_d;
	logic [CNT_EXT_W-1:0]    cnt_ext;
	logic                    emit;

	logic                    out_v_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_user_q;
	logic                    out_last_q;

	// An item is taken from the queue whenever the output register is free or being drained.
	assign q_pop = q_valid && (!out_v_q || m_tready);

	// Group decode of the item at the head of the queue.
	always_comb begin
		skip   = (pos_q == POS_FIRST) && q_item.is_break;
		have   = 1'b0;
		byte_d = 8'd0;
		pos_d  = pos_q;
		if (!skip) begin
			unique case (pos_q)
				POS_FIRST: begin
					pos_d = POS_SECOND;
				end
				POS_SECOND: begin
					have   = 1'b1;
					byte_d = {prev_q, q_item.sextet[5:4]};
					pos_d  = POS_THIRD;
				end
				POS_THIRD: begin
					have   = !q_item.is_pad;
					byte_d = q_item.is_pad ? 8'd0 : {prev_q[3:0], q_item.sextet[5:2]};
					pos_d  = POS_FOURTH;
				end
				POS_FOURTH: begin
					have   = !q_item.is_pad;
					byte_d = q_item.is_pad ? 8'd0 : {prev_q[1:0], q_item.sextet};
					pos_d  = POS_FIRST;
				end
				default: begin
					pos_d = POS_FIRST;
				end
			endcase
		end
		cnt_d   = (have && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		cnt_ext = CNT_EXT_W'(cnt_d);
		emit    = have || q_item.last;
	end

	// Decoder state; the final character of a text starts the next one fresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_FIRST;
			prev_q <= '0;
			cnt_q  <= '0;
		end else if (q_pop) begin
			if (q_item.last) begin
				pos_q  <= POS_FIRST;
				prev_q <= '0;
				cnt_q  <= '0;
			end else begin
				pos_q <= pos_d;
				cnt_q <= cnt_d;
				if (!skip) begin
					prev_q <= q_item.sextet;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q <= q_pop && emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_data_q <= {cnt_ext[BYTE_COUNT_W-1:0], byte_d};
			out_user_q <= have;
			out_last_q <= q_item.last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/base64_stream_decoder_top.sv =====
// An item's result passes through the classification register, the queue and the output register.
// Throughput: one character per cycle, sustained while the output side keeps up.
// The two-entry queue between classification and decode absorbs output stalls.
// Reset (arst_n low) empties all stages and clears group position, sextet and count.
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder: one character in per item, at most one decoded
// byte out per item, with a running byte count and an end-of-text marker.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top import b64d_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] char_in
	input  logic                   s_tlast,   // end_of_text
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] byte_out, [23:8] byte_count
	output logic                   m_tuser,   // byte_valid
	output logic                   m_tlast    // end_of_data
);

	logic              push_valid;
	logic              push_ready;
	class_t            push_item;
	logic              q_valid;
	logic              q_pop;
	class_t            q_item;
	logic [QLVL_W-1:0] q_level;

	// Character classification.
	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Queue between front and back.
	b64d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item),
		.level      (q_level)
	);

	// Group decode and result output.
	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A result without a byte exists only for the final character.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without byte is not marked final");

	// The queue never holds more entries than it has.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QLVL_W'(QDEPTH))
		else $error("queue level beyond depth");

	// Input stalls only when the classification stage is held by a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> push_valid && !push_ready && q_level == QLVL_W'(QDEPTH))
		else $error("input stalled without a full queue");

	// The back never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_level != '0)
		else $error("pop from empty queue");

endmodule
